@@ rtl/lbf_pkg.sv @@
// ----------------------------------------------------------------------------
// lbf_pkg: shared types for the line, box and frame pixel generator
// Holds the opcode and segment codes, coordinate widths, and the decoded
// command that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package lbf_pkg;

  // Widest coordinate that the ports carry.
  localparam int CoordMaxW = 16;
  localparam int DeltaW    = CoordMaxW + 1;
  localparam int ErrW      = CoordMaxW + 3;
  localparam int ColorW    = 8;

  typedef logic signed [CoordMaxW-1:0] coord_t;
  typedef logic        [DeltaW-1:0]    delta_t;
  typedef logic signed [ErrW-1:0]      err_t;
  typedef logic        [ColorW-1:0]    color_t;

  // Command codes as they arrive on the input tuser.
  typedef enum logic [1:0] {
    OP_LINE  = 2'd0,
    OP_BOX   = 2'd1,
    OP_FRAME = 2'd2,
    OP_STEP  = 2'd3
  } lbf_op_t;

  // Kind of the segment being walked.
  typedef enum logic [1:0] {
    SEG_H = 2'd0,
    SEG_V = 2'd1,
    SEG_D = 2'd2
  } lbf_seg_t;

  // Decoded command: start items carry their first segment fully set up.
  typedef struct packed {
    lbf_op_t  op;
    lbf_seg_t seg;
    logic     box_empty;
    coord_t   cur_x;
    coord_t   cur_y;
    coord_t   end_x;
    coord_t   end_y;
    coord_t   x_a;
    coord_t   x_b;
    coord_t   y_b;
    coord_t   x_lo;
    coord_t   x_hi;
    coord_t   y_lo;
    coord_t   y_hi;
    delta_t   dx;
    delta_t   dy;
    logic     sx_neg;
    logic     sy_neg;
    err_t     err;
    color_t   color;
  } lbf_cmd_t;

  // Status reported by the back end.
  typedef struct packed {
    logic busy;
    logic pop;
  } lbf_status_t;

endpackage

@@ rtl/lbf_front.sv @@
// ----------------------------------------------------------------------------
// lbf_front: command decoder
// Sign-extends the corner coordinates, orders them, and sets up the first
// segment of each figure, including the Bresenham terms of a diagonal line.
// ----------------------------------------------------------------------------
module lbf_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic [1:0]                  op_raw,
  input  logic [lbf_pkg::CoordMaxW-1:0] x_a_raw,
  input  logic [lbf_pkg::CoordMaxW-1:0] y_a_raw,
  input  logic [lbf_pkg::CoordMaxW-1:0] x_b_raw,
  input  logic [lbf_pkg::CoordMaxW-1:0] y_b_raw,
  input  logic [lbf_pkg::ColorW-1:0]    color_raw,
  output lbf_pkg::lbf_cmd_t             cmd
);
  import lbf_pkg::*;

  localparam int Shift = CoordMaxW - COORD_WIDTH;

  coord_t xa, ya, xb, yb;
  coord_t x_lo, x_hi, y_lo, y_hi;
  logic   eq_x, eq_y;
  delta_t dx, dy;

  // Keep the low COORD_WIDTH bits and sign-extend them to the port width.
  function automatic coord_t sext_coord(input logic [CoordMaxW-1:0] raw);
    logic [CoordMaxW-1:0] up;
    up = raw << Shift;
    return $signed(up) >>> Shift;
  endfunction

  // Order the corners and take the absolute spans.
  always_comb begin
    xa   = sext_coord(x_a_raw);
    ya   = sext_coord(y_a_raw);
    xb   = sext_coord(x_b_raw);
    yb   = sext_coord(y_b_raw);
    x_lo = (xa < xb) ? xa : xb;
    x_hi = (xa < xb) ? xb : xa;
    y_lo = (ya < yb) ? ya : yb;
    y_hi = (ya < yb) ? yb : ya;
    eq_x = (xa == xb);
    eq_y = (ya == yb);
    dx   = delta_t'($signed({x_hi[CoordMaxW-1], x_hi}) - $signed({x_lo[CoordMaxW-1], x_lo}));
    dy   = delta_t'($signed({y_hi[CoordMaxW-1], y_hi}) - $signed({y_lo[CoordMaxW-1], y_lo}));
  end

  // Build the command with its first segment.
  always_comb begin
    cmd           = '0;
    cmd.op        = lbf_op_t'(op_raw);
    cmd.box_empty = (ya > yb);
    cmd.x_a       = xa;
    cmd.x_b       = xb;
    cmd.y_b       = yb;
    cmd.x_lo      = x_lo;
    cmd.x_hi      = x_hi;
    cmd.y_lo      = y_lo;
    cmd.y_hi      = y_hi;
    cmd.dx        = dx;
    cmd.dy        = dy;
    cmd.sx_neg    = (xb < xa);
    cmd.sy_neg    = (yb < ya);
    cmd.err       = err_t'($signed({2'b00, dx}) - $signed({2'b00, dy}));
    cmd.color     = color_raw;
    // Box rows and the first frame edge are horizontal at the first corner's y.
    cmd.seg       = SEG_H;
    cmd.cur_x     = x_lo;
    cmd.end_x     = x_hi;
    cmd.cur_y     = ya;
    cmd.end_y     = ya;
    if (cmd.op == OP_LINE) begin
      if (eq_y) begin
        cmd.seg = SEG_H;
      end else if (eq_x) begin
        cmd.seg   = SEG_V;
        cmd.cur_x = xa;
        cmd.end_x = xa;
        cmd.cur_y = y_lo;
        cmd.end_y = y_hi;
      end else begin
        cmd.seg   = SEG_D;
        cmd.cur_x = xa;
        cmd.cur_y = ya;
        cmd.end_x = xb;
        cmd.end_y = yb;
      end
    end
  end

endmodule

@@ rtl/lbf_queue.sv @@
// ----------------------------------------------------------------------------
// lbf_queue: two-entry command queue
// Decouples the decoder from the rasterizer so either side can stall alone.
// ----------------------------------------------------------------------------
module lbf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lbf_pkg::lbf_cmd_t push_cmd,
  output logic              can_push,
  input  logic              pop,
  output logic              head_valid,
  output lbf_pkg::lbf_cmd_t head_cmd
);
  import lbf_pkg::*;

  lbf_cmd_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign can_push   = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/lbf_back.sv @@
// ----------------------------------------------------------------------------
// lbf_back: figure rasterizer
// Executes queued commands: a start loads the figure, a step while busy
// emits the current pixel into the output register and walks one pixel on.
// ----------------------------------------------------------------------------
module lbf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  lbf_pkg::lbf_cmd_t   head_cmd,
  output lbf_pkg::lbf_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output lbf_pkg::coord_t     out_x,
  output lbf_pkg::coord_t     out_y,
  output lbf_pkg::color_t     out_color,
  output logic                out_last
);
  import lbf_pkg::*;

  logic     busy_r, busy_nxt;
  lbf_op_t  fig_r, fig_nxt;
  logic [1:0] seg_idx_r, seg_idx_nxt;
  lbf_seg_t seg_r, seg_nxt;
  coord_t   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t   end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  coord_t   xa_r, xa_nxt, xb_r, xb_nxt, yb_r, yb_nxt;
  coord_t   x_lo_r, x_lo_nxt, x_hi_r, x_hi_nxt;
  coord_t   y_lo_r, y_lo_nxt, y_hi_r, y_hi_nxt;
  delta_t   dx_r, dx_nxt, dy_r, dy_nxt;
  logic     sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  err_t     err_r, err_nxt;
  color_t   color_r, color_nxt;

  logic     ov_r, ov_nxt;
  coord_t   ox_r, ox_nxt, oy_r, oy_nxt;
  color_t   oc_r, oc_nxt;
  logic     ol_r, ol_nxt;

  logic     out_free, pop, seg_done, last;
  logic signed [ErrW:0] twice, neg_dy, pos_dx;
  logic     step_x, step_y;

  assign out_free    = !ov_r || out_ready;
  assign pop         = head_valid && ((head_cmd.op != OP_STEP) || out_free);
  assign status.busy = busy_r;
  assign status.pop  = pop;

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_color = oc_r;
  assign out_last  = ol_r;

  // Bresenham error tests for a diagonal step.
  always_comb begin
    twice  = {err_r, 1'b0};
    neg_dy = -$signed({3'b000, dy_r});
    pos_dx = $signed({3'b000, dx_r});
    step_x = (twice > neg_dy);
    step_y = (twice < pos_dx);
  end

  // Command execution.
  always_comb begin
    busy_nxt    = busy_r;
    fig_nxt     = fig_r;
    seg_idx_nxt = seg_idx_r;
    seg_nxt     = seg_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    end_x_nxt   = end_x_r;
    end_y_nxt   = end_y_r;
    xa_nxt      = xa_r;
    xb_nxt      = xb_r;
    yb_nxt      = yb_r;
    x_lo_nxt    = x_lo_r;
    x_hi_nxt    = x_hi_r;
    y_lo_nxt    = y_lo_r;
    y_hi_nxt    = y_hi_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    sx_neg_nxt  = sx_neg_r;
    sy_neg_nxt  = sy_neg_r;
    err_nxt     = err_r;
    color_nxt   = color_r;
    ov_nxt      = ov_r && !out_ready;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    oc_nxt      = oc_r;
    ol_nxt      = ol_r;
    seg_done    = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
    last        = 1'b0;

    if (pop && (head_cmd.op != OP_STEP)) begin
      // A start replaces any figure in progress.
      busy_nxt    = !((head_cmd.op == OP_BOX) && head_cmd.box_empty);
      fig_nxt     = head_cmd.op;
      seg_idx_nxt = 2'd0;
      seg_nxt     = head_cmd.seg;
      cur_x_nxt   = head_cmd.cur_x;
      cur_y_nxt   = head_cmd.cur_y;
      end_x_nxt   = head_cmd.end_x;
      end_y_nxt   = head_cmd.end_y;
      xa_nxt      = head_cmd.x_a;
      xb_nxt      = head_cmd.x_b;
      yb_nxt      = head_cmd.y_b;
      x_lo_nxt    = head_cmd.x_lo;
      x_hi_nxt    = head_cmd.x_hi;
      y_lo_nxt    = head_cmd.y_lo;
      y_hi_nxt    = head_cmd.y_hi;
      dx_nxt      = head_cmd.dx;
      dy_nxt      = head_cmd.dy;
      sx_neg_nxt  = head_cmd.sx_neg;
      sy_neg_nxt  = head_cmd.sy_neg;
      err_nxt     = head_cmd.err;
      color_nxt   = head_cmd.color;
    end else if (pop && busy_r) begin
      // Emit the current pixel, then move to the next one.
      ov_nxt = 1'b1;
      ox_nxt = cur_x_r;
      oy_nxt = cur_y_r;
      oc_nxt = color_r;
      if (!seg_done) begin
        case (seg_r)
          SEG_H: cur_x_nxt = cur_x_r + coord_t'(1);
          SEG_V: cur_y_nxt = cur_y_r + coord_t'(1);
          default: begin
            err_nxt = err_r - (step_x ? err_t'(dy_r) : '0) + (step_y ? err_t'(dx_r) : '0);
            if (step_x) begin
              cur_x_nxt = sx_neg_r ? cur_x_r - coord_t'(1) : cur_x_r + coord_t'(1);
            end
            if (step_y) begin
              cur_y_nxt = sy_neg_r ? cur_y_r - coord_t'(1) : cur_y_r + coord_t'(1);
            end
          end
        endcase
      end else begin
        case (fig_r)
          OP_BOX: begin
            if (cur_y_r == y_hi_r) begin
              last = 1'b1;
            end else begin
              seg_nxt   = SEG_H;
              cur_x_nxt = x_lo_r;
              end_x_nxt = x_hi_r;
              cur_y_nxt = cur_y_r + coord_t'(1);
              end_y_nxt = cur_y_r + coord_t'(1);
            end
          end
          OP_FRAME: begin
            if (seg_idx_r == 2'd3) begin
              last = 1'b1;
            end else begin
              seg_idx_nxt = seg_idx_r + 2'd1;
              case (seg_idx_r)
                2'd0: begin
                  seg_nxt   = SEG_H;
                  cur_x_nxt = x_lo_r;
                  end_x_nxt = x_hi_r;
                  cur_y_nxt = yb_r;
                  end_y_nxt = yb_r;
                end
                2'd1: begin
                  seg_nxt   = SEG_V;
                  cur_x_nxt = xa_r;
                  end_x_nxt = xa_r;
                  cur_y_nxt = y_lo_r;
                  end_y_nxt = y_hi_r;
                end
                default: begin
                  seg_nxt   = SEG_V;
                  cur_x_nxt = xb_r;
                  end_x_nxt = xb_r;
                  cur_y_nxt = y_lo_r;
                  end_y_nxt = y_hi_r;
                end
              endcase
            end
          end
          default: last = 1'b1;
        endcase
      end
      ol_nxt = last;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      fig_r     <= OP_LINE;
      seg_idx_r <= 2'd0;
      seg_r     <= SEG_H;
      ov_r      <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      fig_r     <= fig_nxt;
      seg_idx_r <= seg_idx_nxt;
      seg_r     <= seg_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    end_x_r  <= end_x_nxt;
    end_y_r  <= end_y_nxt;
    xa_r     <= xa_nxt;
    xb_r     <= xb_nxt;
    yb_r     <= yb_nxt;
    x_lo_r   <= x_lo_nxt;
    x_hi_r   <= x_hi_nxt;
    y_lo_r   <= y_lo_nxt;
    y_hi_r   <= y_hi_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    sx_neg_r <= sx_neg_nxt;
    sy_neg_r <= sy_neg_nxt;
    err_r    <= err_nxt;
    color_r  <= color_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oc_r     <= oc_nxt;
    ol_r     <= ol_nxt;
  end

endmodule

@@ rtl/line_box_frame_pixel_generator.sv @@
// A step transaction's pixel goes through the command queue and then the output
// register. Throughput: one transaction per cycle while out_tready keeps the output
// register free for steps, set by the Bresenham update in the rasterizer; a start
// transaction produces no output.
// Reset: synchronous, active low; clears the queue, the busy flag and the output.
// ----------------------------------------------------------------------------
// line_box_frame_pixel_generator: line, box and frame pixel generator
// A decoder classifies drawing commands, a two-entry queue holds them, and a
// rasterizer walks lines, box rows and frame edges one pixel per step.
// ----------------------------------------------------------------------------
module line_box_frame_pixel_generator #(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_a[15:0], y_a[31:16], x_b[47:32], y_b[63:48], color[71:64]
  input  logic [71:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_x[15:0], pixel_y[31:16], pixel_color[39:32]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);
  import lbf_pkg::*;

  lbf_cmd_t    dec_cmd, head_cmd;
  logic        can_push, head_valid;
  lbf_status_t status;
  coord_t      px, py;
  color_t      pc;

  assign in_tready = can_push;
  assign out_tdata = {pc, py, px};

  lbf_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .op_raw   (in_tuser),
    .x_a_raw  (in_tdata[15:0]),
    .y_a_raw  (in_tdata[31:16]),
    .x_b_raw  (in_tdata[47:32]),
    .y_b_raw  (in_tdata[63:48]),
    .color_raw(in_tdata[71:64]),
    .cmd      (dec_cmd)
  );

  lbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && can_push),
    .push_cmd  (dec_cmd),
    .can_push  (can_push),
    .pop       (status.pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  lbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (px),
    .out_y     (py),
    .out_color (pc),
    .out_last  (out_tlast)
  );

`ifndef SYNTH
  // The rasterizer only takes commands the queue actually holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    status.pop |-> head_valid)
    else $error("command taken from an empty queue");

  // A step on a busy figure puts a pixel in the output register.
  a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (status.pop && head_cmd.op == OP_STEP && status.busy) |=> out_tvalid)
    else $error("step on busy figure produced no pixel");

  // A start of a non-empty figure makes the rasterizer busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (status.pop && head_cmd.op != OP_STEP &&
     !(head_cmd.op == OP_BOX && head_cmd.box_empty)) |=> status.busy)
    else $error("start did not load a figure");
`endif

endmodule
